// ----- hw/rtl/rre_pkg.sv -----
package rre_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MASK   = 7'h7f;
  localparam int unsigned        LITERAL_BIT  = 7;

  localparam logic [1:0] LANES_NONE = 2'd0;
  localparam logic [1:0] LANES_ONE  = 2'd1;
  localparam logic [1:0] LANES_TWO  = 2'd2;

  localparam logic CFG_IN_WORD_16  = 1'b0;
  localparam logic CFG_OUT_WORD_16 = 1'b1;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_RUN,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [WORD_W-1:0]  pixel;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] pixel_a;
    logic [WORD_W-1:0] pixel_b;
    logic [1:0]        pixels_valid;
    logic              row_end;
    logic              last;
  } res_t;

endpackage

// ----- hw/rtl/rre_cmd_fifo.sv -----
module rre_cmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_wr;
  logic do_rd;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rre_front.sv -----
module rre_front import rre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_word_16,
  input  logic              out_word_16,
  input  logic              push,
  input  logic [WORD_W-1:0] code_word,
  input  logic              cmd_full,
  output logic              cmd_push,
  output cmd_t              cmd
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_RUN
  } phase_t;

  phase_t             phase;
  phase_t             phase_next;
  logic [COUNT_W-1:0] remaining;
  logic [COUNT_W-1:0] remaining_next;

  logic               accept;
  logic [WORD_W-1:0]  w;
  logic [WORD_W-1:0]  pix;
  logic [COUNT_W-1:0] hdr_count;

  assign accept    = push && !cmd_full;
  assign w         = in_word_16 ? code_word : {8'h00, code_word[7:0]};
  assign pix       = out_word_16 ? w : {8'h00, w[7:0]};
  assign hdr_count = w[COUNT_W-1:0] & COUNT_MASK;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    cmd_push       = 1'b0;
    cmd.kind       = CMD_LIT;
    cmd.pixel      = pix;
    cmd.count      = remaining;
    unique case (phase)
      PH_LITERAL: begin
        cmd_push       = accept;
        cmd.kind       = CMD_LIT;
        remaining_next = remaining - 1'b1;
        if (remaining_next == '0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_RUN: begin
        cmd_push       = accept;
        cmd.kind       = CMD_RUN;
        remaining_next = '0;
        phase_next     = PH_HEADER;
      end
      default: begin
        if (hdr_count == '0) begin
          cmd_push       = accept;
          cmd.kind       = CMD_END;
          cmd.pixel      = '0;
          remaining_next = '0;
          phase_next     = PH_HEADER;
        end else begin
          remaining_next = hdr_count;
          phase_next     = w[LITERAL_BIT] ? PH_LITERAL : PH_RUN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

endmodule

// ----- hw/rtl/rre_back.sv -----
module rre_back import rre_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_valid,
  output res_t res,
  input  logic res_pop
);

  logic               busy;
  logic               busy_next;
  logic [COUNT_W-1:0] left;
  logic [COUNT_W-1:0] left_next;
  logic [WORD_W-1:0]  pix;
  logic [WORD_W-1:0]  pix_next;
  res_t               res_next;

  logic               load_ok;
  logic               start;
  logic               step;
  logic [COUNT_W-1:0] src_n;
  logic [WORD_W-1:0]  src_pix;
  logic               two;
  logic [COUNT_W-1:0] rem;

  assign load_ok = !res_valid || res_pop;
  assign start   = !busy && cmd_valid && load_ok;
  assign step    = busy && load_ok;
  assign cmd_pop = start;

  assign src_n   = busy ? left : cmd.count;
  assign src_pix = busy ? pix : cmd.pixel;
  assign two     = (src_n[COUNT_W-1:1] != '0);
  assign rem     = src_n - (two ? COUNT_W'(2) : COUNT_W'(1));

  always_comb begin
    busy_next             = busy;
    left_next             = left;
    pix_next              = pix;
    res_next.pixel_a      = src_pix;
    res_next.pixel_b      = two ? src_pix : '0;
    res_next.pixels_valid = two ? LANES_TWO : LANES_ONE;
    res_next.row_end      = 1'b0;
    res_next.last         = (rem == '0);
    if (step) begin
      busy_next = (rem != '0);
      left_next = rem;
    end else if (start) begin
      unique case (cmd.kind)
        CMD_RUN: begin
          busy_next = (rem != '0);
          left_next = rem;
          pix_next  = src_pix;
        end
        CMD_END: begin
          res_next.pixel_a      = '0;
          res_next.pixel_b      = '0;
          res_next.pixels_valid = LANES_NONE;
          res_next.row_end      = 1'b1;
          res_next.last         = 1'b1;
        end
        default: begin
          res_next.pixel_a      = src_pix;
          res_next.pixel_b      = '0;
          res_next.pixels_valid = LANES_ONE;
          res_next.last         = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (start || step) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    left <= left_next;
    pix  <= pix_next;
    if (start || step) begin
      res <= res_next;
    end
  end

endmodule

// ----- hw/rtl/rle_row_expander.sv -----
// Run-length row expander. Each code word beat is taken when push is high and
// full is low; header words are decoded in the front end and produce no
// result, while literals, run values and zero-count headers are queued as
// commands for the back end. The back end emits one result beat per cycle
// while results are popped: one for a literal or row end, ceil(count/2) for a
// run (two pixels per beat, last set on the final beat of each word). Input
// therefore runs at one word per cycle until the command queue (CMD_DEPTH
// entries) fills, which happens when runs longer than four pixels keep the
// expander busy or the result side holds off pop. Write the configuration
// registers only while the block is idle.
module rle_row_expander import rre_pkg::*; #(
  parameter int unsigned CMD_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic              cfg_wdata,
  input  logic              push,
  output logic              full,
  input  logic [WORD_W-1:0] code_word,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] pixel_a,
  output logic [WORD_W-1:0] pixel_b,
  output logic [1:0]        pixels_valid,
  output logic              row_end,
  output logic              last
);

  logic in_word_16;
  logic out_word_16;

  logic cmd_push;
  logic cmd_full;
  cmd_t cmd_in;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_out;
  logic res_valid;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word_16  <= 1'b0;
      out_word_16 <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IN_WORD_16:  in_word_16  <= cfg_wdata;
        CFG_OUT_WORD_16: out_word_16 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rre_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_word_16  (in_word_16),
    .out_word_16 (out_word_16),
    .push        (push),
    .code_word   (code_word),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  rre_cmd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  rre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign full         = cmd_full;
  assign empty        = !res_valid;
  assign pixel_a      = res.pixel_a;
  assign pixel_b      = res.pixel_b;
  assign pixels_valid = res.pixels_valid;
  assign row_end      = res.row_end;
  assign last         = res.last;

endmodule
